// File: hw/rtl/bvp_pkg.sv
// ----------------------------------------------------------------------------
// bvp_pkg
// types and anchor table shared by the battery voltage to percent pipeline
// ----------------------------------------------------------------------------
package bvp_pkg;

  localparam int unsigned MvW     = 16;
  localparam int unsigned PctW    = 7;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned DiffW   = 6;
  localparam int unsigned NumW    = 10;
  localparam int unsigned QW      = 3;
  localparam int unsigned AnchorN = 21;

  localparam logic [MvW-1:0]  ThresholdReset = 16'd3990;
  localparam logic [PctW-1:0] PctFull        = 7'd100;
  localparam logic [PctW-1:0] PctEmpty       = 7'd0;
  localparam logic [NumW-1:0] PctStepX2      = 10'd10;
  localparam logic [IdxW-1:0] LastIdx        = 5'd20;

  localparam logic [MvW-1:0] ANCHOR_MV [AnchorN] = '{
    16'd3750, 16'd3698, 16'd3645, 16'd3593, 16'd3540, 16'd3488, 16'd3435,
    16'd3383, 16'd3330, 16'd3278, 16'd3225, 16'd3173, 16'd3120, 16'd3068,
    16'd3015, 16'd2963, 16'd2910, 16'd2858, 16'd2805, 16'd2753, 16'd2700
  };

  localparam logic [PctW-1:0] ANCHOR_PCT [AnchorN] = '{
    7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
    7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
    7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
  };

  typedef struct packed {
    logic            sat_hi;
    logic            sat_lo;
    logic [IdxW-1:0] seg;
    logic [MvW-1:0]  mv;
    logic            charging;
  } seg_t;

  typedef struct packed {
    logic [PctW-1:0]  lo_pct;
    logic [NumW-1:0]  num;
    logic [DiffW-1:0] d;
    logic             charging;
  } interp_t;

endpackage

// File: hw/rtl/battery_voltage_to_percent_top.sv
// ----------------------------------------------------------------------------
// battery_voltage_to_percent_top
// battery voltage in mV to charge percent and charging flag, three stages
// ----------------------------------------------------------------------------
//  port group  | direction | signals
//  ------------+-----------+---------------------------------------------
//  sample in   | in        | valid_i, stall_o, voltage_mv_i
//  result out  | out       | valid_o, stall_i, percent_o, charging_o
//  config      | in        | cfg_we_i, cfg_data_i (charging threshold)
//
//  one transfer per cycle sustained while stall_i stays low, each stage registered
//  stages: anchor compares, interpolation numerator, quotient and sum
//  each stage loads when empty or when the next one moves, so bubbles collapse
//  reset empties the pipeline and sets the threshold to 3990 mV
// ----------------------------------------------------------------------------
module battery_voltage_to_percent_top (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [bvp_pkg::MvW-1:0]  voltage_mv_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [bvp_pkg::PctW-1:0] percent_o,
  output logic                     charging_o,
  input  logic                     cfg_we_i,
  input  logic [bvp_pkg::MvW-1:0]  cfg_data_i
);

  logic [bvp_pkg::MvW-1:0] threshold_q;
  logic                    seg_valid;
  logic                    seg_stall;
  bvp_pkg::seg_t           seg;
  logic                    interp_valid;
  logic                    interp_stall;
  bvp_pkg::interp_t        interp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= bvp_pkg::ThresholdReset;
    end else if (cfg_we_i) begin
      threshold_q <= cfg_data_i;
    end
  end

  bvp_seg u_seg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .voltage_mv_i (voltage_mv_i),
    .threshold_i  (threshold_q),
    .valid_o      (seg_valid),
    .stall_i      (seg_stall),
    .seg_o        (seg)
  );

  bvp_interp u_interp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (seg_valid),
    .stall_o  (seg_stall),
    .seg_i    (seg),
    .valid_o  (interp_valid),
    .stall_i  (interp_stall),
    .interp_o (interp)
  );

  bvp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (interp_valid),
    .stall_o    (interp_stall),
    .interp_i   (interp),
    .valid_o    (valid_o),
    .stall_i    (stall_i),
    .percent_o  (percent_o),
    .charging_o (charging_o)
  );

endmodule

// File: hw/rtl/bvp_seg.sv
// ----------------------------------------------------------------------------
// bvp_seg
// first stage: anchor compares, segment select and charging compare
// ----------------------------------------------------------------------------
module bvp_seg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  logic [bvp_pkg::MvW-1:0]  voltage_mv_i,
  input  logic [bvp_pkg::MvW-1:0]  threshold_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output bvp_pkg::seg_t            seg_o
);

  logic          valid_q;
  logic          load;
  bvp_pkg::seg_t seg_d;
  bvp_pkg::seg_t seg_q;

  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;

  always_comb begin
    seg_d.sat_hi   = voltage_mv_i >= bvp_pkg::ANCHOR_MV[0];
    seg_d.sat_lo   = voltage_mv_i <= bvp_pkg::ANCHOR_MV[bvp_pkg::AnchorN-1];
    seg_d.mv       = voltage_mv_i;
    seg_d.charging = voltage_mv_i > threshold_i;
    seg_d.seg      = bvp_pkg::LastIdx;
    // smallest index whose anchor is at or below the voltage
    for (int k = bvp_pkg::AnchorN - 1; k >= 1; k--) begin
      if (voltage_mv_i >= bvp_pkg::ANCHOR_MV[k]) begin
        seg_d.seg = bvp_pkg::IdxW'(k);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      seg_q <= seg_d;
    end
  end

  assign valid_o = valid_q;
  assign seg_o   = seg_q;

endmodule

// File: hw/rtl/bvp_interp.sv
// ----------------------------------------------------------------------------
// bvp_interp
// second stage: offset into the segment and rounding numerator
// ----------------------------------------------------------------------------
module bvp_interp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  bvp_pkg::seg_t    seg_i,
  output logic             valid_o,
  input  logic             stall_i,
  output bvp_pkg::interp_t interp_o
);

  logic                          valid_q;
  logic                          load;
  logic [bvp_pkg::MvW-1:0]       lo_mv;
  logic [bvp_pkg::MvW-1:0]       hi_mv;
  logic [bvp_pkg::MvW-1:0]       span;
  logic [bvp_pkg::MvW-1:0]       offs;
  logic [bvp_pkg::DiffW-1:0]     x;
  bvp_pkg::interp_t              interp_d;
  bvp_pkg::interp_t              interp_q;

  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;

  always_comb begin
    lo_mv = bvp_pkg::ANCHOR_MV[seg_i.seg];
    hi_mv = bvp_pkg::ANCHOR_MV[seg_i.seg - 1'b1];
    span  = hi_mv - lo_mv;
    offs  = seg_i.mv - lo_mv;
    x     = offs[bvp_pkg::DiffW-1:0];

    interp_d.charging = seg_i.charging;
    interp_d.d        = span[bvp_pkg::DiffW-1:0];
    if (seg_i.sat_hi) begin
      interp_d.lo_pct = bvp_pkg::PctFull;
      interp_d.num    = '0;
    end else if (seg_i.sat_lo) begin
      interp_d.lo_pct = bvp_pkg::PctEmpty;
      interp_d.num    = '0;
    end else begin
      interp_d.lo_pct = bvp_pkg::ANCHOR_PCT[seg_i.seg];
      // 2 * x * step + d, rounding half up after the divide
      interp_d.num    = bvp_pkg::NumW'(x) * bvp_pkg::PctStepX2
                      + bvp_pkg::NumW'(span[bvp_pkg::DiffW-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      interp_q <= interp_d;
    end
  end

  assign valid_o  = valid_q;
  assign interp_o = interp_q;

endmodule

// File: hw/rtl/bvp_div.sv
// ----------------------------------------------------------------------------
// bvp_div
// last stage: small quotient by parallel compares, percent sum, output register
// ----------------------------------------------------------------------------
module bvp_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     valid_i,
  output logic                     stall_o,
  input  bvp_pkg::interp_t         interp_i,
  output logic                     valid_o,
  input  logic                     stall_i,
  output logic [bvp_pkg::PctW-1:0] percent_o,
  output logic                     charging_o
);

  localparam int unsigned QMax = (1 << bvp_pkg::QW) - 3;

  logic                       valid_q;
  logic                       load;
  logic [bvp_pkg::NumW-1:0]   two_d;
  logic [bvp_pkg::QW-1:0]     q;
  logic [bvp_pkg::PctW-1:0]   percent_d;
  logic [bvp_pkg::PctW-1:0]   percent_q;
  logic                       charging_q;

  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;

  always_comb begin
    two_d = bvp_pkg::NumW'({interp_i.d, 1'b0});
    q     = '0;
    // quotient never exceeds five since the offset stays below the span
    for (int t = 1; t <= QMax; t++) begin
      if (interp_i.num >= bvp_pkg::NumW'(t) * two_d) begin
        q = q + 1'b1;
      end
    end
    percent_d = interp_i.lo_pct + bvp_pkg::PctW'(q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load && valid_i) begin
      percent_q  <= percent_d;
      charging_q <= interp_i.charging;
    end
  end

  assign valid_o    = valid_q;
  assign percent_o  = percent_q;
  assign charging_o = charging_q;

endmodule
